// ----- rtl/cdrp_pkg.sv -----
`default_nettype none
package cdrp_pkg;

  localparam int unsigned CFG_W   = 8;
  localparam int unsigned MANT_W  = 31;
  localparam int unsigned FRAC_W  = 4;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned LEN_W   = 8;

  localparam logic [7:0] SEP_BYTE   = 8'h2C;
  localparam logic [7:0] MINUS_BYTE = 8'h2D;
  localparam logic [7:0] POINT_BYTE = 8'h2E;
  localparam logic [7:0] ZERO_BYTE  = 8'h30;
  localparam logic [7:0] NINE_BYTE  = 8'h39;

  localparam logic [COUNT_W-1:0] MAX_FIELDS_RST  = 6'd20;
  localparam logic [LEN_W-1:0]   MIN_ROW_LEN_RST = 8'd4;

  typedef enum logic {
    CFG_MAX_FIELDS  = 1'b0,
    CFG_MIN_ROW_LEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIGIT,
    OP_MINUS,
    OP_POINT,
    OP_SEP
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_ZERO  = 2'd2
  } row_status_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       row_last;
  } in_item_t;

  typedef struct packed {
    logic signed [MANT_W-1:0] value_mantissa;
    logic [FRAC_W-1:0]        frac_digits;
    logic                     has_value;
    logic                     digits_dropped;
    logic                     row_end;
    logic [COUNT_W-1:0]       field_count;
    logic [1:0]               row_status;
  } out_item_t;

  // classified byte handed from front to back
  typedef struct packed {
    op_e        op;
    logic [3:0] digit;
    logic       last;
    logic       short_row;
  } op_word_t;

endpackage
`default_nettype wire

// ----- rtl/cdrp_front.sv -----
`default_nettype none
module cdrp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  cdrp_pkg::in_item_t     in_data_i,
  input  logic [7:0]             min_row_len_i,
  output logic                   push_o,
  output cdrp_pkg::op_word_t     push_word_o,
  input  logic                   full_i
);
  import cdrp_pkg::*;

  logic             at_start_q, at_start_d;
  logic [LEN_W-1:0] bytes_q, bytes_d;
  logic [LEN_W-1:0] bytes_inc;
  logic             accept;
  logic [7:0]       c;

  assign c          = in_data_i.char_byte;
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    bytes_inc = (bytes_q == {LEN_W{1'b1}}) ? bytes_q : bytes_q + 1'b1;

    push_word_o.digit     = c[3:0];
    push_word_o.last      = in_data_i.row_last;
    push_word_o.short_row = bytes_inc < min_row_len_i;
    if (c == SEP_BYTE) begin
      push_word_o.op = OP_SEP;
    end else if (c == MINUS_BYTE && at_start_q) begin
      push_word_o.op = OP_MINUS;
    end else if (c == POINT_BYTE) begin
      push_word_o.op = OP_POINT;
    end else if (c >= ZERO_BYTE && c <= NINE_BYTE) begin
      push_word_o.op = OP_DIGIT;
    end else begin
      push_word_o.op = OP_NONE;
    end

    at_start_d = at_start_q;
    bytes_d    = bytes_q;
    if (accept) begin
      if (in_data_i.row_last) begin
        at_start_d = 1'b1;
        bytes_d    = '0;
      end else begin
        at_start_d = (c == SEP_BYTE);
        bytes_d    = bytes_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      bytes_q    <= '0;
    end else begin
      at_start_q <= at_start_d;
      bytes_q    <= bytes_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cdrp_fifo.sv -----
`default_nettype none
module cdrp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cdrp_pkg::op_word_t push_word_i,
  output logic               full_o,
  input  logic               pop_i,
  output cdrp_pkg::op_word_t pop_word_o,
  output logic               empty_o
);
  import cdrp_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  op_word_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign pop_word_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cdrp_back.sv -----
`default_nettype none
module cdrp_back #(
  parameter int unsigned MaxDigits = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cdrp_pkg::op_word_t      word_i,
  input  logic                    word_valid_i,
  output logic                    pop_o,
  input  logic [5:0]              max_fields_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output cdrp_pkg::out_item_t     out_data_o
);
  import cdrp_pkg::*;

  localparam int unsigned Keep = (MaxDigits < 9) ? MaxDigits : 9;
  localparam int unsigned AccW = $clog2(10 ** Keep);
  localparam int unsigned DcW  = $clog2(Keep + 1);
  localparam logic [DcW-1:0] KeepCnt = DcW'(Keep);

  logic [AccW-1:0]    acc_q, acc_d;
  logic [DcW-1:0]     dcnt_q, dcnt_d;
  logic [DcW-1:0]     frac_q, frac_d;
  logic               pt_q, pt_d;
  logic               neg_q, neg_d;
  logic               drop_q, drop_d;
  logic [COUNT_W-1:0] fields_q, fields_n;
  logic               fz_q, fz_n;

  logic [AccW+3:0]    acc_x10;
  logic [MANT_W-1:0]  mag;
  logic               closing, store, emit, ready;
  out_item_t          res;
  logic               out_valid_q;
  out_item_t          out_q;

  assign ready       = !out_valid_q || !out_stall_i;
  assign pop_o       = word_valid_i && ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {{AccW{1'b0}}, word_i.digit};
    acc_d   = acc_q;
    dcnt_d  = dcnt_q;
    frac_d  = frac_q;
    pt_d    = pt_q;
    neg_d   = neg_q;
    drop_d  = drop_q;
    unique case (word_i.op)
      OP_DIGIT: begin
        if (dcnt_q < KeepCnt) begin
          acc_d  = acc_x10[AccW-1:0];
          dcnt_d = dcnt_q + 1'b1;
          if (pt_q) begin
            frac_d = frac_q + 1'b1;
          end
        end else begin
          drop_d = 1'b1;
        end
      end
      OP_MINUS: neg_d = 1'b1;
      OP_POINT: pt_d = 1'b1;
      default: ;
    endcase

    closing  = (word_i.op == OP_SEP) || word_i.last;
    store    = closing && (fields_q < max_fields_i);
    emit     = store || word_i.last;
    fields_n = fields_q + COUNT_W'(store);
    fz_n     = (store && fields_q == '0) ? (acc_d == '0) : fz_q;
    mag      = MANT_W'(acc_d);

    res = '0;
    if (store) begin
      res.value_mantissa = neg_d ? -mag : mag;
      res.frac_digits    = FRAC_W'(frac_d);
      res.has_value      = 1'b1;
      res.digits_dropped = drop_d;
    end
    if (word_i.last) begin
      res.row_end     = 1'b1;
      res.field_count = fields_n;
      if (word_i.short_row) begin
        res.row_status = STATUS_SHORT;
      end else if (fields_n != '0 && fz_n) begin
        res.row_status = STATUS_ZERO;
      end else begin
        res.row_status = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      dcnt_q      <= '0;
      frac_q      <= '0;
      pt_q        <= 1'b0;
      neg_q       <= 1'b0;
      drop_q      <= 1'b0;
      fields_q    <= '0;
      fz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (closing) begin
          acc_q  <= '0;
          dcnt_q <= '0;
          frac_q <= '0;
          pt_q   <= 1'b0;
          neg_q  <= 1'b0;
          drop_q <= 1'b0;
        end else begin
          acc_q  <= acc_d;
          dcnt_q <= dcnt_d;
          frac_q <= frac_d;
          pt_q   <= pt_d;
          neg_q  <= neg_d;
          drop_q <= drop_d;
        end
        if (word_i.last) begin
          fields_q <= '0;
          fz_q     <= 1'b0;
        end else if (closing) begin
          fields_q <= fields_n;
          fz_q     <= fz_n;
        end
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= res;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/csv_decimal_row_parser.sv -----
`default_nettype none
// Parses a comma-separated ASCII row, one byte word per cycle sustained, into exact decimal
// fields (signed mantissa plus fraction digit count). A byte is classified on entry and
// queued; the back end takes one queued word per cycle while its output is not stalled, and
// its multiply-by-ten-and-add on the field accumulator sets that rate. Results are
// registered; the input stalls only when the queue fills behind a stalled output.
module csv_decimal_row_parser #(
  parameter int unsigned MAX_DIGITS = 9,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_index_i,
  input  logic [cdrp_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  cdrp_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output cdrp_pkg::out_item_t         out_data_o
);
  import cdrp_pkg::*;

  logic [COUNT_W-1:0] max_fields_q;
  logic [LEN_W-1:0]   min_row_len_q;

  logic     push, full, pop, empty;
  op_word_t push_word, pop_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fields_q  <= MAX_FIELDS_RST;
      min_row_len_q <= MIN_ROW_LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_MAX_FIELDS) begin
        max_fields_q <= cfg_wdata_i[COUNT_W-1:0];
      end else begin
        min_row_len_q <= cfg_wdata_i[LEN_W-1:0];
      end
    end
  end

  cdrp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .min_row_len_i (min_row_len_q),
    .push_o        (push),
    .push_word_o   (push_word),
    .full_i        (full)
  );

  cdrp_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .pop_i       (pop),
    .pop_word_o  (pop_word),
    .empty_o     (empty)
  );

  cdrp_back #(
    .MaxDigits (MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (pop_word),
    .word_valid_i (!empty),
    .pop_o        (pop),
    .max_fields_i (max_fields_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

// ----- verif/csv_decimal_row_parser_tb.sv -----
`timescale 1ns / 1ps
module csv_decimal_row_parser_tb;
  import cdrp_pkg::*;

  localparam int KEEP_DIGITS = 9;
  localparam int PER_PHASE   = 275;
  localparam int N_PHASES    = 7;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 10;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_index_i = CFG_MAX_FIELDS;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  csv_decimal_row_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // parser state as seen from outside
  logic [5:0]  max_fields_q = MAX_FIELDS_RST;
  logic [7:0]  min_len_q    = MIN_ROW_LEN_RST;
  logic [29:0] acc          = '0;
  logic [3:0]  frac_cnt     = '0;
  logic [3:0]  dig_cnt      = '0;
  logic        pt_seen      = 1'b0;
  logic        neg          = 1'b0;
  logic        at_start     = 1'b1;
  logic        dropped      = 1'b0;
  logic [5:0]  fld_cnt      = '0;
  logic        first_zero   = 1'b0;
  logic [7:0]  byte_cnt     = '0;

  out_item_t   pending_fields[$];
  int          errors      = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  int          stall_mode  = 0;
  int          stall_timer = 0;
  int          run_left    = 0;
  bit          run_val     = 1'b0;

  typedef struct {
    logic [7:0] ch;
    bit         last;
    bit         typed;
    out_item_t  res;
  } dir_row_t;

  dir_row_t dir_tab [25] = '{
    '{"1", 1, 1, '{31'sd1, 4'd0, 1'b1, 1'b0, 1'b1, 6'd1, STATUS_SHORT}},
    '{"-", 0, 0, '0},
    '{"0", 0, 0, '0},
    '{",", 0, 1, '{31'sd0, 4'd0, 1'b1, 1'b0, 1'b0, 6'd0, STATUS_OK}},
    '{"9", 1, 1, '{31'sd9, 4'd0, 1'b1, 1'b0, 1'b1, 6'd2, STATUS_ZERO}},
    '{"-", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{".", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{"9", 0, 0, '0},
    '{",", 1, 1, '{-31'sd999999999, 4'd1, 1'b1, 1'b1, 1'b1, 6'd1, STATUS_OK}},
    '{",", 0, 1, '{31'sd0, 4'd0, 1'b1, 1'b0, 1'b0, 6'd0, STATUS_OK}},
    '{8'h00, 0, 0, '0},
    '{8'hFF, 1, 1, '{31'sd0, 4'd0, 1'b1, 1'b0, 1'b1, 6'd2, STATUS_SHORT}},
    '{".", 0, 0, '0},
    '{"5", 0, 0, '0},
    '{"-", 0, 0, '0},
    '{".", 1, 1, '{31'sd5, 4'd1, 1'b1, 1'b0, 1'b1, 6'd1, STATUS_OK}}
  };

  task automatic clear_field();
    acc      = '0;
    frac_cnt = '0;
    dig_cnt  = '0;
    pt_seen  = 1'b0;
    neg      = 1'b0;
    at_start = 1'b1;
    dropped  = 1'b0;
  endtask

  task automatic close_field(output bit kept, output out_item_t r);
    r    = '0;
    kept = 1'b0;
    if (fld_cnt < max_fields_q) begin
      r.value_mantissa = neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
      r.frac_digits    = frac_cnt;
      r.has_value      = 1'b1;
      r.digits_dropped = dropped;
      if (fld_cnt == 0) first_zero = (acc == 0);
      fld_cnt = fld_cnt + 1'b1;
      kept    = 1'b1;
    end
    clear_field();
  endtask

  task automatic parse_byte(input in_item_t w, output bit got, output out_item_t r);
    got = 1'b0;
    r   = '0;
    if (byte_cnt != 8'hFF) byte_cnt = byte_cnt + 1'b1;
    if (w.char_byte == SEP_BYTE) begin
      close_field(got, r);
    end else begin
      if (w.char_byte == MINUS_BYTE && at_start) begin
        neg = 1'b1;
      end else if (w.char_byte == POINT_BYTE) begin
        pt_seen = 1'b1;
      end else if (w.char_byte >= ZERO_BYTE && w.char_byte <= NINE_BYTE) begin
        if (dig_cnt < KEEP_DIGITS) begin
          acc     = 30'(acc * 10 + (w.char_byte - ZERO_BYTE));
          dig_cnt = dig_cnt + 1'b1;
          if (pt_seen) frac_cnt = frac_cnt + 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
      at_start = 1'b0;
      if (w.row_last) close_field(got, r);
    end
    if (w.row_last) begin
      r.row_end     = 1'b1;
      r.field_count = fld_cnt;
      if (byte_cnt < min_len_q) r.row_status = STATUS_SHORT;
      else if (fld_cnt > 0 && first_zero) r.row_status = STATUS_ZERO;
      else r.row_status = STATUS_OK;
      got = 1'b1;
      clear_field();
      fld_cnt    = '0;
      first_zero = 1'b0;
      byte_cnt   = '0;
    end
  endtask

  task automatic log_mismatch(input string what, input out_item_t e, input out_item_t a);
    errors++;
    if (errors <= 10) begin
      $display("%s at %0t", what, $realtime);
      $display("  exp mant=%0d frac=%0d has=%b drop=%b end=%b cnt=%0d st=%0d",
               e.value_mantissa, e.frac_digits, e.has_value, e.digits_dropped,
               e.row_end, e.field_count, e.row_status);
      $display("  got mant=%0d frac=%0d has=%b drop=%b end=%b cnt=%0d st=%0d",
               a.value_mantissa, a.frac_digits, a.has_value, a.digits_dropped,
               a.row_end, a.field_count, a.row_status);
    end
  endtask

  // drive one word in bursts; predict once it is taken
  task automatic send_word(input in_item_t w, input bit typed, input out_item_t typed_res);
    bit        got;
    out_item_t res;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    parse_byte(w, got, res);
    if (typed) pending_fields.push_back(typed_res);
    else if (got) pending_fields.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [5:0] mf, input logic [7:0] len);
    in_valid_i <= 1'b0;
    while (pending_fields.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MAX_FIELDS;
    cfg_wdata_i <= {2'($urandom), mf};
    @(negedge clk_i);
    cfg_index_i <= CFG_MIN_ROW_LEN;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    max_fields_q = mf;
    min_len_q    = len;
    burst_left   = 0;
  endtask

  always @(negedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_timer = $urandom_range(16, 200);
    end else begin
      stall_timer--;
    end
    if (run_left == 0) begin
      run_left = $urandom_range(1, 12);
      run_val  = ~run_val;
    end
    run_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= run_val;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** csv_decimal_row_parser: FAILED **");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_fields.size() == 0) begin
          log_mismatch("word with nothing expected", '0, out_data_o);
        end else begin
          out_item_t e;
          e = pending_fields.pop_front();
          if (out_data_o.value_mantissa !== e.value_mantissa ||
              out_data_o.frac_digits    !== e.frac_digits    ||
              out_data_o.has_value      !== e.has_value      ||
              out_data_o.digits_dropped !== e.digits_dropped ||
              out_data_o.row_end        !== e.row_end        ||
              out_data_o.field_count    !== e.field_count    ||
              out_data_o.row_status     !== e.row_status)
            log_mismatch("mismatch", e, out_data_o);
        end
      end
    end
  end

  initial begin
    logic [5:0] ph_mf [N_PHASES];
    logic [7:0] ph_len [N_PHASES];
    in_item_t   row[$];
    logic [7:0] ch;
    int         sent, nf, nd, ppos;

    ph_mf  = '{6'd1, 6'd63, 6'd0, 6'd3, 6'($urandom_range(1, 63)),
               6'($urandom_range(1, 63)), MAX_FIELDS_RST};
    ph_len = '{8'd0, 8'd255, 8'd12, 8'd1, 8'($urandom_range(0, 40)),
               8'($urandom_range(0, 255)), MIN_ROW_LEN_RST};

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i])
      send_word('{dir_tab[i].ch, dir_tab[i].last}, dir_tab[i].typed, dir_tab[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      write_cfg(ph_mf[p], ph_len[p]);
      sent = 0;
      while (sent < PER_PHASE) begin
        row.delete();
        // long rows reach the byte counter's saturation
        if ((min_len_q == 8'd255 && sent == 0) || $urandom_range(0, 59) == 0)
          repeat (256) row.push_back('{8'h20, 1'b0});
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 16)) begin
            ch = ($urandom_range(0, 3) == 0) ? SEP_BYTE : 8'($urandom_range(0, 255));
            row.push_back('{ch, 1'b0});
          end
        end else begin
          nf = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
          for (int f = 0; f < nf; f++) begin
            if (f > 0) row.push_back('{SEP_BYTE, 1'b0});
            if ($urandom_range(0, 2) == 0) row.push_back('{MINUS_BYTE, 1'b0});
            nd   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 5);
            ppos = $urandom_range(0, nd + 2);
            for (int d = 0; d < nd; d++) begin
              if (d == ppos) row.push_back('{POINT_BYTE, 1'b0});
              if ($urandom_range(0, 11) == 0) begin
                ch = 8'($urandom_range(0, 255));
                if (ch == SEP_BYTE) ch = POINT_BYTE;
                row.push_back('{ch, 1'b0});
              end
              ch = 8'(ZERO_BYTE + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9)));
              row.push_back('{ch, 1'b0});
            end
          end
          if ($urandom_range(0, 5) == 0) row.push_back('{SEP_BYTE, 1'b0});
        end
        row[row.size() - 1].row_last = 1'b1;
        foreach (row[i]) send_word(row[i], 1'b0, '0);
        sent += row.size();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_fields.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (errors == 0 && pending_fields.size() == 0) begin
      $display("** csv_decimal_row_parser: PASSED **");
    end else begin
      $display("** csv_decimal_row_parser: FAILED **");
    end
    $finish;
  end

endmodule

// ----- csv_decimal_row_parser.f -----
rtl/cdrp_pkg.sv
rtl/cdrp_front.sv
rtl/cdrp_fifo.sv
rtl/cdrp_back.sv
rtl/csv_decimal_row_parser.sv
verif/csv_decimal_row_parser_tb.sv
